FILE: sv/fcc_pkg.sv
// fcc_pkg: shared constants, types and codes of the FIR convolve/correlate block.
// No dependencies; imported by the cell, the config port and the top level.
`default_nettype none

package fcc_pkg;

    // sizes
    localparam int MAX_TAPS      = 64;
    localparam int SAMPLE_BITS   = 16;
    localparam int PROD_BITS     = 2 * SAMPLE_BITS;
    localparam int RESULT_BITS   = 2 * SAMPLE_BITS + 6;
    localparam int TAP_IDX_BITS  = $clog2(MAX_TAPS);
    localparam int TAPS_W        = 7;                        // tap_count register width
    localparam int CNT_BITS      = $clog2(MAX_TAPS + 2);
    localparam int CALC_CYCLES   = MAX_TAPS + 1;             // product stage + sum ripple
    localparam int IN_TDATA_BITS  = ((TAP_IDX_BITS + SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

    // input kinds (tuser)
    localparam logic MODE_TAP    = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // register indexes
    localparam logic REG_TAP_COUNT = 1'b0;
    localparam logic REG_CORRELATE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_CALC
    } t_state;

    // controls broadcast along the cell row
    typedef struct packed {
        logic win_shift;
        logic win_clear;
        logic tap_shift;
    } t_cell_ctrl;

    typedef struct packed {
        logic [TAPS_W-1:0] tap_count;
        logic              correlate;
    } t_cfg;

endpackage

`default_nettype wire

FILE: sv/fcc_ram.sv
// fcc_ram: generic single-write, single-read RAM with registered read data.
// Standalone; holds the tap store.
`default_nettype none

module fcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/fcc_cell.sv
// fcc_cell: one cell of the row: a delay-line sample, a working tap,
// a registered product and one stage of the rippling partial sum. Uses fcc_pkg.
`default_nettype none

module fcc_cell
    import fcc_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cell_ctrl                    i_ctrl,
    input  wire logic                          i_active,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_tap,
    input  wire logic signed [RESULT_BITS-1:0] i_psum,
    output logic signed      [SAMPLE_BITS-1:0] o_sample,
    output logic signed      [SAMPLE_BITS-1:0] o_tap,
    output logic signed      [RESULT_BITS-1:0] o_psum
);

    logic signed [SAMPLE_BITS-1:0] r_w;
    logic signed [SAMPLE_BITS-1:0] r_t;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [RESULT_BITS-1:0] r_psum;

    // delay-line sample: cleared by reset and at end of signal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.win_clear) begin
            r_w <= '0;
        end else if (i_ctrl.win_shift) begin
            r_w <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.tap_shift) begin
            r_t <= i_tap;
        end
    end

    // cells past the tap count contribute nothing
    always_ff @(posedge i_clk) begin
        r_prod <= i_active ? PROD_BITS'(r_w * r_t) : '0;
        r_psum <= i_psum + {{(RESULT_BITS-PROD_BITS){r_prod[PROD_BITS-1]}}, r_prod};
    end

    assign o_sample = r_w;
    assign o_tap    = r_t;
    assign o_psum   = r_psum;

endmodule

`default_nettype wire

FILE: sv/fcc_apb.sv
// fcc_apb: APB register port holding tap_count and correlate.
// Uses fcc_pkg.
`default_nettype none

module fcc_apb
    import fcc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg,
    output logic             o_cfg_wr
);

    logic [TAPS_W-1:0] r_tap_count;
    logic              r_correlate;
    logic              wr;

    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAPS_W'(1);
            r_correlate <= 1'b0;
        end else if (wr) begin
            unique case (paddr[2])
                REG_TAP_COUNT: r_tap_count <= pwdata[TAPS_W-1:0];
                REG_CORRELATE: r_correlate <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TAP_COUNT: prdata = {{(32-TAPS_W){1'b0}}, r_tap_count};
            REG_CORRELATE: prdata = {31'd0, r_correlate};
        endcase
    end

    assign pready          = 1'b1;
    assign o_cfg.tap_count = r_tap_count;
    assign o_cfg.correlate = r_correlate;
    assign o_cfg_wr        = wr;

endmodule

`default_nettype wire

FILE: sv/fir_convolve_correlate.sv
// fir_convolve_correlate: top level; sequencer, tap RAM, row of 64 cells, output register.
// Depends on fcc_pkg, fcc_ram, fcc_cell and fcc_apb.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata{value,tap_index}, tuser mode, tlast end
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata{result}, tlast last
//  apb       in   psel & penable & pwrite        tap_count @0x0, correlate @0x4
//
// Sequence: a tap beat is taken at once and the block stays ready for the next beat. A
// sample beat shifts the delay line at once; if taps or registers changed since the last
// sample, the working taps are first reloaded from the tap RAM (one RAM read per cycle).
// Each result then goes through the registered cell products, the partial sum rippling
// down the cell row and the load of the output register. An end-flagged sample yields P
// results; the next beat is taken in the cycle after the last result is loaded.
// Reset clears the delay line and control; tap RAM contents stay undefined until loaded.
// One output register holds a finished result; the next result is computed meanwhile and
// the row stalls only when that one is done and the register is still full.
`default_nettype none

module fir_convolve_correlate
    import fcc_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // sample / tap stream
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // [5:0] tap_index, [21:6] value
    input  wire logic                      s_axis_tuser,   // [0] mode
    input  wire logic                      s_axis_tlast,   // end_of_signal
    // result stream
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata,   // [37:0] result
    output logic                           m_axis_tlast,   // last
    // register port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready
);

    // ---------------- configuration ----------------
    t_cfg              cfg;
    logic              cfg_wr;
    logic [CNT_BITS-1:0] p_eff;   // tap count clamped to 1..MAX_TAPS

    fcc_apb u_apb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (cfg),
        .o_cfg_wr (cfg_wr)
    );

    always_comb begin
        if (cfg.tap_count == '0) begin
            p_eff = CNT_BITS'(1);
        end else if (CNT_BITS'(cfg.tap_count) > CNT_BITS'(MAX_TAPS)) begin
            p_eff = CNT_BITS'(MAX_TAPS);
        end else begin
            p_eff = CNT_BITS'(cfg.tap_count);
        end
    end

    // ---------------- input beat fields ----------------
    logic [TAP_IDX_BITS-1:0]       in_idx;
    logic signed [SAMPLE_BITS-1:0] in_value;
    logic                          in_fire;
    logic                          out_fire;

    assign in_idx   = s_axis_tdata[TAP_IDX_BITS-1:0];
    assign in_value = s_axis_tdata[TAP_IDX_BITS +: SAMPLE_BITS];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // ---------------- sequencer registers ----------------
    t_state              r_state,   n_state;
    logic [CNT_BITS-1:0] r_cnt,     n_cnt;
    logic                r_rd_vld,  n_rd_vld;
    logic [CNT_BITS-1:0] r_tail,    n_tail;    // tail outputs still to produce
    logic                r_end,     n_end;
    logic                r_dirty,   n_dirty;   // working taps stale
    logic                r_out_valid, n_out_valid;
    logic signed [RESULT_BITS-1:0] r_out_data;
    logic                r_out_last;

    t_cell_ctrl                    ctrl;
    logic signed [SAMPLE_BITS-1:0] win_in;
    logic                          ram_we;
    logic                          ram_re;
    logic [CNT_BITS-1:0]           rd_off;
    logic [TAP_IDX_BITS-1:0]       ram_raddr;
    logic signed [SAMPLE_BITS-1:0] ram_rdata;
    logic                          out_load;
    logic                          out_last;
    logic signed [RESULT_BITS-1:0] row_sum;

    // conv loads taps in order P-1..0, correlation 0..P-1, so that after P shifts
    // cell k holds tap[k] or tap[P-1-k]
    assign rd_off    = cfg.correlate ? r_cnt : (p_eff - CNT_BITS'(1) - r_cnt);
    assign ram_raddr = rd_off[TAP_IDX_BITS-1:0];
    assign win_in    = in_fire ? in_value : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_tail      <= '0;
            r_end       <= 1'b0;
            r_dirty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rd_vld    <= n_rd_vld;
            r_tail      <= n_tail;
            r_end       <= n_end;
            r_dirty     <= n_dirty;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= row_sum;
            r_out_last <= out_last;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_rd_vld       = 1'b0;
        n_tail         = r_tail;
        n_end          = r_end;
        n_dirty        = r_dirty || cfg_wr;
        ctrl.win_shift = 1'b0;
        ctrl.win_clear = 1'b0;
        ctrl.tap_shift = r_rd_vld;
        s_axis_tready  = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        out_load       = 1'b0;
        out_last       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_fire) begin
                    if (s_axis_tuser == MODE_TAP) begin
                        // index beyond the tap count is dropped
                        ram_we  = {1'b0, in_idx} < p_eff;
                        n_dirty = 1'b1;
                    end else begin
                        ctrl.win_shift = 1'b1;
                        n_end   = s_axis_tlast;
                        n_tail  = s_axis_tlast ? (p_eff - CNT_BITS'(1)) : '0;
                        n_cnt   = '0;
                        n_state = r_dirty ? ST_PREP : ST_CALC;
                    end
                end
            end
            ST_PREP: begin
                ram_re   = r_cnt < p_eff;
                n_rd_vld = ram_re;
                if (ram_re) begin
                    n_cnt = r_cnt + CNT_BITS'(1);
                end else if (!r_rd_vld) begin
                    n_cnt   = '0;
                    n_dirty = 1'b0;
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (r_cnt != CNT_BITS'(CALC_CYCLES)) begin
                    n_cnt = r_cnt + CNT_BITS'(1);
                end else if (!r_out_valid || out_fire) begin
                    out_load = 1'b1;
                    out_last = r_end && (r_tail == '0);
                    if (r_tail != '0) begin
                        // next tail output: shift a zero in and sweep again
                        ctrl.win_shift = 1'b1;
                        n_tail = r_tail - CNT_BITS'(1);
                        n_cnt  = '0;
                    end else begin
                        ctrl.win_clear = r_end;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // ---------------- tap store ----------------
    fcc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_idx),
        .i_wdata (in_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------- cell row ----------------
    logic signed [SAMPLE_BITS-1:0] samp_chain [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] tap_chain  [MAX_TAPS];
    logic signed [RESULT_BITS-1:0] sum_chain  [MAX_TAPS];

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] samp_in;
        logic signed [SAMPLE_BITS-1:0] tap_in;
        logic signed [RESULT_BITS-1:0] sum_in;
        logic                          active;

        if (k == 0) begin : g_head
            assign samp_in = win_in;
            assign tap_in  = ram_rdata;
            assign sum_in  = '0;
        end else begin : g_body
            assign samp_in = samp_chain[k-1];
            assign tap_in  = tap_chain[k-1];
            assign sum_in  = sum_chain[k-1];
        end

        assign active = CNT_BITS'(k) < p_eff;

        fcc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (ctrl),
            .i_active (active),
            .i_sample (samp_in),
            .i_tap    (tap_in),
            .i_psum   (sum_in),
            .o_sample (samp_chain[k]),
            .o_tap    (tap_chain[k]),
            .o_psum   (sum_chain[k])
        );
    end

    assign row_sum = sum_chain[MAX_TAPS-1];

    // ---------------- result stream ----------------
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_BITS-RESULT_BITS){1'b0}}, r_out_data};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire
